>>> sv/dgn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and constants for the damped gauge needle core.
package dgn_pkg;

    localparam int Q_FRAC   = 16;                    // Q16.16 fraction bits
    localparam int VAL_W    = 32;                    // signed Q16.16 value
    localparam int UVAL_W   = 31;                    // unsigned Q15.16 value
    localparam int PROD_W   = 64;                    // full product width
    localparam int OPA_W    = 33;                    // signed multiplicand / divisor
    localparam int S_W      = PROD_W - 1 - Q_FRAC;   // scaled amount width
    localparam int SUM_W    = 50;                    // exact sum width before saturation
    localparam int LIM_W    = 33;                    // scale + offset
    localparam int MUL_STEPS = UVAL_W;
    localparam int DIV_STEPS = VAL_W;
    localparam int CNT_W    = $clog2(DIV_STEPS);

    localparam int WRAP_DEG = 360;
    // (360 << 32) / scale reaches 2^31 exactly when scale <= 2 * 360
    localparam int WRAP_SAT_SCALE = 2 * WRAP_DEG;

    localparam logic [UVAL_W-1:0] SCALE_RESET = 31'd65536;

    typedef enum logic [2:0] {
        CMD_SET  = 3'd0,
        CMD_PUT  = 3'd1,
        CMD_INC  = 3'd2,
        CMD_DEC  = 3'd3,
        CMD_WRAP = 3'd4,
        CMD_TICK = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        REG_SCALE    = 2'd0,
        REG_OFFSET   = 2'd1,
        REG_FRICTION = 2'd2
    } t_reg_idx;

    typedef enum logic {
        IT_MUL = 1'b0,
        IT_DIV = 1'b1
    } t_iter_mode;

    typedef struct packed {
        logic       start;
        t_iter_mode mode;
    } t_iter_cmd;

endpackage
`default_nettype wire

>>> sv/dgn_iter.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared bit-serial unit: shift-add multiply and restoring divide on one 64-bit adder.
module dgn_iter
    import dgn_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_iter_cmd                i_cmd,
    input  logic signed [OPA_W-1:0]  i_opa,
    input  logic [UVAL_W-1:0]        i_opb,
    input  logic [VAL_W-1:0]         i_div_hi,
    input  logic [VAL_W-1:0]         i_div_lo,
    output logic                     o_done,
    output logic signed [PROD_W-1:0] o_product,
    output logic [VAL_W-1:0]         o_quotient
);

    t_iter_mode               r_mode, n_mode;
    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [PROD_W-1:0]        r_acc, n_acc;
    logic [VAL_W-1:0]         r_q, n_q;
    logic [UVAL_W-1:0]        r_b, n_b;
    logic signed [OPA_W-1:0]  r_m, n_m;

    logic [PROD_W-1:0]        w_add_a;
    logic [PROD_W-1:0]        w_add_b;
    logic [PROD_W-1:0]        w_sum;
    logic                     w_cin;
    logic [VAL_W-1:0]         w_shift;

    // the one adder; divide uses it as a subtractor (sign bit = borrow)
    always_comb begin
        w_shift = {r_acc[VAL_W-2:0], r_q[VAL_W-1]};
        if (r_mode == IT_DIV) begin
            w_add_a = {{(PROD_W-VAL_W-1){1'b0}}, r_acc[VAL_W-1:0], r_q[VAL_W-1]};
            w_add_b = ~{{(PROD_W-UVAL_W){1'b0}}, r_m[UVAL_W-1:0]};
            w_cin   = 1'b1;
        end else begin
            w_add_a = {r_acc[PROD_W-2:0], 1'b0};
            w_add_b = r_b[UVAL_W-1] ? PROD_W'(r_m) : '0;
            w_cin   = 1'b0;
        end
        w_sum = w_add_a + w_add_b + PROD_W'(w_cin);
    end

    always_comb begin
        n_mode = r_mode;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_q    = r_q;
        n_b    = r_b;
        n_m    = r_m;
        if (i_cmd.start) begin
            n_mode = i_cmd.mode;
            n_busy = 1'b1;
            n_m    = i_opa;
            n_b    = i_opb;
            if (i_cmd.mode == IT_DIV) begin
                n_cnt = CNT_W'(DIV_STEPS - 1);
                n_acc = {{(PROD_W-VAL_W){1'b0}}, i_div_hi};
                n_q   = i_div_lo;
            end else begin
                n_cnt = CNT_W'(MUL_STEPS - 1);
                n_acc = '0;
            end
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
            if (r_mode == IT_DIV) begin
                n_acc = {{(PROD_W-VAL_W){1'b0}},
                         (w_sum[PROD_W-1] ? w_shift : w_sum[VAL_W-1:0])};
                n_q   = {r_q[VAL_W-2:0], ~w_sum[PROD_W-1]};
            end else begin
                n_acc = w_sum;
                n_b   = {r_b[UVAL_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_q    <= n_q;
        r_b    <= n_b;
        r_m    <= n_m;
    end

    assign o_done     = r_done;
    assign o_product  = r_acc;
    assign o_quotient = r_q;

endmodule
`default_nettype wire

>>> sv/damped_gauge_needle_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Set, put, increment and decrement run a multiply on the shared serial unit (31-step
// multiply, 32-step divide); wrap increment adds a divide unless scale <= 720; a damped
// tick runs a multiply then a divide; a jumping tick and an unused command skip the unit.
// One request at a time; the next is taken the cycle after the result is loaded, even
// while that result still waits downstream. Synchronous active-low reset:
// scale = 1.0, offset = friction = 0, needle = target = 0, no result pending.
module damped_gauge_needle_core
    import dgn_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [VAL_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [2:0]              i_command,
    input  logic signed [VAL_W-1:0] i_amount,
    input  logic [UVAL_W-1:0]       i_time_step,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_needle_value,
    output logic signed [VAL_W-1:0] o_target_value
);

    // Sequencer: IDLE takes a request and launches the multiply or, for a jumping tick
    // or unused code, goes to OUT; MUL waits on it (and launches a divide for tick, or for
    // wrap when scale > 720), DIV waits, SUM/ADJ/FIN add exactly, clamp, saturate, OUT hands over.
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_SUM  = 7'b0001000,
        ST_ADJ  = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(32'sh8000_0000);

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [VAL_W-1:0] res;
        if (v > SAT_HI) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[VAL_W-1:0];
        end
        return res;
    endfunction

    // control and architectural state
    t_state                   r_state, n_state;
    logic [UVAL_W-1:0]        r_scale, n_scale;
    logic signed [VAL_W-1:0]  r_offset, n_offset;
    logic [UVAL_W-1:0]        r_friction, n_friction;
    logic signed [VAL_W-1:0]  r_needle, n_needle;
    logic signed [VAL_W-1:0]  r_target, n_target;
    logic                     r_out_valid, n_out_valid;

    // per-request working registers
    t_cmd                     r_cmd, n_cmd;
    logic signed [S_W-1:0]    r_s, n_s;        // floor(amount * scale) in Q31.16
    logic                     r_neg, n_neg;    // tick moves the needle down
    logic [UVAL_W-1:0]        r_q, n_q;        // tick step magnitude
    logic [UVAL_W-1:0]        r_w, n_w;        // wrap span 360 / scale
    logic signed [SUM_W-1:0]  r_t, n_t;
    logic signed [LIM_W-1:0]  r_lim, n_lim;    // scale + offset
    logic [UVAL_W-1:0]        r_wsub, n_wsub;  // span taken off on wrap, else 0
    logic signed [VAL_W-1:0]  r_out_needle, n_out_needle;
    logic signed [VAL_W-1:0]  r_out_target, n_out_target;

    // shared unit hookup
    t_iter_cmd                w_it_cmd;
    logic signed [OPA_W-1:0]  w_it_opa;
    logic [UVAL_W-1:0]        w_it_opb;
    logic [VAL_W-1:0]         w_it_hi;
    logic [VAL_W-1:0]         w_it_lo;
    logic                     w_it_done;
    logic signed [PROD_W-1:0] w_it_prod;
    logic [VAL_W-1:0]         w_it_quo;

    logic                     w_jump;
    logic [PROD_W-1:0]        w_mag;
    logic signed [SUM_W-1:0]  w_fin;

    dgn_iter u_iter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_it_cmd),
        .i_opa      (w_it_opa),
        .i_opb      (w_it_opb),
        .i_div_hi   (w_it_hi),
        .i_div_lo   (w_it_lo),
        .o_done     (w_it_done),
        .o_product  (w_it_prod),
        .o_quotient (w_it_quo)
    );

    // needle snaps onto target: no damping, or step at least half the time constant
    assign w_jump = (r_friction == '0) || ({i_time_step, 1'b0} >= {1'b0, r_friction});
    assign w_mag  = w_it_prod[PROD_W-1] ? PROD_W'(-w_it_prod) : PROD_W'(w_it_prod);

    always_comb begin
        n_state      = r_state;
        n_scale      = r_scale;
        n_offset     = r_offset;
        n_friction   = r_friction;
        n_needle     = r_needle;
        n_target     = r_target;
        n_out_valid  = r_out_valid;
        n_cmd        = r_cmd;
        n_s          = r_s;
        n_neg        = r_neg;
        n_q          = r_q;
        n_w          = r_w;
        n_t          = r_t;
        n_lim        = r_lim;
        n_wsub       = r_wsub;
        n_out_needle = r_out_needle;
        n_out_target = r_out_target;
        w_it_cmd.start = 1'b0;
        w_it_cmd.mode  = IT_MUL;
        w_it_opa     = '0;
        w_it_opb     = '0;
        w_it_hi      = '0;
        w_it_lo      = '0;
        w_fin        = r_t;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // config lands only while idle; unknown index is dropped
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SCALE:    n_scale    = i_cfg_data[UVAL_W-1:0];
                REG_OFFSET:   n_offset   = i_cfg_data;
                REG_FRICTION: n_friction = i_cfg_data[UVAL_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = t_cmd'(i_command);
                    case (t_cmd'(i_command))
                        CMD_SET, CMD_PUT, CMD_INC, CMD_DEC, CMD_WRAP: begin
                            w_it_cmd.start = 1'b1;
                            w_it_opa       = OPA_W'(i_amount);
                            w_it_opb       = r_scale;
                            n_state        = ST_MUL;
                        end
                        CMD_TICK: begin
                            if (w_jump) begin
                                n_needle = r_target;
                                n_state  = ST_OUT;
                            end else begin
                                // signed (target - needle) * dt, magnitude taken later
                                w_it_cmd.start = 1'b1;
                                w_it_opa       = OPA_W'(r_target) - OPA_W'(r_needle);
                                w_it_opb       = i_time_step;
                                n_state        = ST_MUL;
                            end
                        end
                        default: n_state = ST_OUT;
                    endcase
                end
            end
            ST_MUL: begin
                if (w_it_done) begin
                    n_s   = w_it_prod[PROD_W-2:Q_FRAC];
                    n_neg = w_it_prod[PROD_W-1];
                    case (r_cmd)
                        CMD_TICK: begin
                            w_it_cmd.start = 1'b1;
                            w_it_cmd.mode  = IT_DIV;
                            w_it_opa       = OPA_W'(r_friction);
                            w_it_hi        = w_mag[PROD_W-1:VAL_W];
                            w_it_lo        = w_mag[VAL_W-1:0];
                            n_state        = ST_DIV;
                        end
                        CMD_WRAP: begin
                            if (r_scale <= UVAL_W'(WRAP_SAT_SCALE)) begin
                                n_w     = '1;   // span saturates (zero scale included)
                                n_state = ST_SUM;
                            end else begin
                                w_it_cmd.start = 1'b1;
                                w_it_cmd.mode  = IT_DIV;
                                w_it_opa       = OPA_W'(r_scale);
                                w_it_hi        = VAL_W'(WRAP_DEG);
                                w_it_lo        = '0;
                                n_state        = ST_DIV;
                            end
                        end
                        default: n_state = ST_SUM;
                    endcase
                end
            end
            ST_DIV: begin
                if (w_it_done) begin
                    if (r_cmd == CMD_TICK) begin
                        n_q = w_it_quo[UVAL_W-1:0];
                    end else begin
                        n_w = w_it_quo[UVAL_W-1:0];
                    end
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                case (r_cmd)
                    CMD_SET, CMD_PUT: n_t = SUM_W'(r_offset) + SUM_W'(r_s);
                    CMD_INC, CMD_WRAP: n_t = SUM_W'(r_target) + SUM_W'(r_s);
                    CMD_DEC: n_t = SUM_W'(r_target) - SUM_W'(r_s);
                    CMD_TICK: begin
                        if (r_neg) begin
                            n_t = SUM_W'(r_needle) - SUM_W'({1'b0, r_q});
                        end else begin
                            n_t = SUM_W'(r_needle) + SUM_W'({1'b0, r_q});
                        end
                    end
                    default: ;
                endcase
                n_lim   = LIM_W'(r_offset) + LIM_W'({1'b0, r_scale});
                n_state = ST_ADJ;
            end
            ST_ADJ: begin
                n_wsub = '0;
                case (r_cmd)
                    CMD_INC, CMD_DEC: n_t = r_t + SUM_W'(r_offset);
                    CMD_WRAP: begin
                        // target + S (before the offset) against the span
                        n_t = r_t + SUM_W'(r_offset);
                        if (r_t > SUM_W'(signed'({1'b0, r_w}))) begin
                            n_wsub = r_w;
                        end
                    end
                    default: ;
                endcase
                n_state = ST_FIN;
            end
            ST_FIN: begin
                case (r_cmd)
                    CMD_SET: n_target = sat32(r_t);
                    CMD_PUT: begin
                        n_target = sat32(r_t);
                        n_needle = sat32(r_t);
                    end
                    CMD_INC: begin
                        w_fin    = (r_t > SUM_W'(r_lim)) ? SUM_W'(r_lim) : r_t;
                        n_target = sat32(w_fin);
                    end
                    CMD_DEC: begin
                        w_fin    = r_t[SUM_W-1] ? '0 : r_t;
                        n_target = sat32(w_fin);
                    end
                    CMD_WRAP: begin
                        w_fin    = r_t - SUM_W'({1'b0, r_wsub});
                        n_target = sat32(w_fin);
                        n_needle = sat32(SUM_W'(r_needle) - SUM_W'({1'b0, r_wsub}));
                    end
                    CMD_TICK: n_needle = sat32(r_t);
                    default: ;
                endcase
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_needle = r_needle;
                    n_out_target = r_target;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scale     <= SCALE_RESET;
            r_offset    <= '0;
            r_friction  <= '0;
            r_needle    <= '0;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scale     <= n_scale;
            r_offset    <= n_offset;
            r_friction  <= n_friction;
            r_needle    <= n_needle;
            r_target    <= n_target;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_s          <= n_s;
        r_neg        <= n_neg;
        r_q          <= n_q;
        r_w          <= n_w;
        r_t          <= n_t;
        r_lim        <= n_lim;
        r_wsub       <= n_wsub;
        r_out_needle <= n_out_needle;
        r_out_target <= n_out_target;
    end

    assign o_cfg_ready    = (r_state == ST_IDLE);
    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_needle_value = r_out_needle;
    assign o_target_value = r_out_target;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while a request is in flight");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_it_done |-> (r_state == ST_MUL || r_state == ST_DIV))
        else $error("serial unit finished outside a wait state");

    a_out_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_OUT))
        else $error("result raised outside the hand-over state");

    a_tick_jump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_command == CMD_TICK && r_friction == '0)
        |=> (r_needle == $past(r_target)))
        else $error("undamped tick did not snap needle to target");
`endif

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for damped_gauge_needle_core: directed and random requests.
module tb
    import dgn_pkg::*;
();

    typedef longint unsigned t_u64;

    // Codes 6 and 7 are not commands; the core must leave its state alone.
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    localparam longint S32_MAX = 64'sh7FFF_FFFF;
    localparam longint S32_MIN = -64'sh8000_0000;
    localparam logic signed [VAL_W-1:0] AMT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] AMT_MIN = 32'sh8000_0000;
    localparam logic [UVAL_W-1:0] DT_MAX = '1;
    localparam int Q_ONE = 1 << Q_FRAC;

    localparam int PHASES = 11;
    localparam int REQS_PER_PHASE = 170;
    localparam int HOLD_CYCLES = 500;   // long receiver hold-off, in cycles

    typedef struct {
        logic [2:0]               command;
        logic signed [VAL_W-1:0]  amount;
        logic [UVAL_W-1:0]        time_step;
    } t_gauge_req;

    typedef struct {
        logic signed [VAL_W-1:0] needle;
        logic signed [VAL_W-1:0] target;
    } t_gauge_pos;

    typedef enum int {RX_OPEN, RX_PATTERN, RX_SPARSE, RX_COIN} t_rx_mode;

    // ---------------------------------------------------------------
    // DUT ports
    // ---------------------------------------------------------------
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [1:0]              i_cfg_index = '0;
    logic [VAL_W-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [2:0]              i_command = '0;
    logic signed [VAL_W-1:0] i_amount = '0;
    logic [UVAL_W-1:0]       i_time_step = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [VAL_W-1:0] o_needle_value;
    logic signed [VAL_W-1:0] o_target_value;

    damped_gauge_needle_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_amount       (i_amount),
        .i_time_step    (i_time_step),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_needle_value (o_needle_value),
        .o_target_value (o_target_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Bench copy of the gauge: registers and needle/target state.
    // Registers change only while the core is idle, so the driver can
    // read them at request accept without any ordering concern.
    // ---------------------------------------------------------------
    logic [UVAL_W-1:0]       cfg_scale = SCALE_RESET;
    logic signed [VAL_W-1:0] cfg_offset = '0;
    logic [UVAL_W-1:0]       cfg_friction = '0;
    logic signed [VAL_W-1:0] needle_pos = '0;
    logic signed [VAL_W-1:0] target_pos = '0;

    t_gauge_req pending_reqs[$];    // requests waiting for the driver
    t_gauge_pos expected_pos[$];    // predicted needle/target, oldest first

    int mismatches = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int settings_used = 0;
    int cmd_seen[8] = '{default: 0};

    function automatic logic signed [VAL_W-1:0] clamp_s32(input longint v);
        if (v > S32_MAX) return S32_MAX[VAL_W-1:0];
        if (v < S32_MIN) return S32_MIN[VAL_W-1:0];
        return v[VAL_W-1:0];
    endfunction

    // Apply one request to the bench state and return needle/target after it.
    function automatic t_gauge_pos advance_gauge(input logic [2:0] cmd,
                                                 input logic signed [VAL_W-1:0] amt,
                                                 input logic [UVAL_W-1:0] dt);
        longint     scaled_amt, t, lim, span, diff;
        t_u64       q, mag;
        t_gauge_pos res;
        // amount * scale, Q32.32 floored back to Q16.16
        scaled_amt = (longint'(amt) * longint'(cfg_scale)) >>> Q_FRAC;
        case (cmd)
            CMD_SET: target_pos = clamp_s32(longint'(cfg_offset) + scaled_amt);
            CMD_PUT: begin
                target_pos = clamp_s32(longint'(cfg_offset) + scaled_amt);
                needle_pos = target_pos;
            end
            CMD_INC: begin
                lim = longint'(cfg_scale) + longint'(cfg_offset);
                t = longint'(target_pos) + scaled_amt + longint'(cfg_offset);
                if (t > lim) t = lim;
                target_pos = clamp_s32(t);
            end
            CMD_DEC: begin
                t = longint'(target_pos) - scaled_amt + longint'(cfg_offset);
                if (t < 0) t = 0;
                target_pos = clamp_s32(t);
            end
            CMD_WRAP: begin
                // span = 360 / scale in Q16.16, saturating; zero scale saturates too
                if (cfg_scale == '0) begin
                    span = S32_MAX;
                end else begin
                    q = (t_u64'(WRAP_DEG) << 32) / t_u64'(cfg_scale);
                    span = (q > t_u64'(S32_MAX)) ? S32_MAX : longint'(q);
                end
                t = longint'(target_pos) + scaled_amt + longint'(cfg_offset);
                if (t - longint'(cfg_offset) > span) begin
                    t = t - span;
                    needle_pos = clamp_s32(longint'(needle_pos) - span);
                end
                target_pos = clamp_s32(t);
            end
            CMD_TICK: begin
                if (cfg_friction == '0 || (t_u64'(dt) << 1) >= t_u64'(cfg_friction)) begin
                    needle_pos = target_pos;
                end else begin
                    diff = longint'(target_pos) - longint'(needle_pos);
                    mag = (diff < 0) ? t_u64'(-diff) : t_u64'(diff);
                    q = (t_u64'(dt) * mag) / t_u64'(cfg_friction);
                    if (diff < 0) needle_pos = clamp_s32(longint'(needle_pos) - longint'(q));
                    else          needle_pos = clamp_s32(longint'(needle_pos) + longint'(q));
                end
            end
            default: ;
        endcase
        res.needle = needle_pos;
        res.target = target_pos;
        return res;
    endfunction

    // Random request. Ticks dominate so the needle spends time converging;
    // step commands mostly use moderate amounts so clamps and wraps get hit.
    function automatic t_gauge_req rand_req();
        t_gauge_req  r;
        int unsigned pick;
        t_u64        half;
        pick = $urandom_range(0, 99);
        if (pick < 30)      r.command = CMD_TICK;
        else if (pick < 45) r.command = CMD_INC;
        else if (pick < 60) r.command = CMD_DEC;
        else if (pick < 75) r.command = CMD_WRAP;
        else if (pick < 86) r.command = CMD_SET;
        else if (pick < 97) r.command = CMD_PUT;
        else if (pick < 99) r.command = CMD_SPARE6;
        else                r.command = CMD_SPARE7;

        case ($urandom_range(0, 9))
            0, 1, 2: r.amount = $signed($urandom_range(0, 16 * Q_ONE)) - 8 * Q_ONE;
            3, 4:    r.amount = $signed($urandom_range(0, 1024 * Q_ONE)) - 512 * Q_ONE;
            5:       r.amount = $signed($urandom_range(0, 511)) - 256;   // fraction only
            6, 7:    r.amount = $urandom;
            8: begin
                case ($urandom_range(0, 3))
                    0:       r.amount = AMT_MAX;
                    1:       r.amount = AMT_MIN;
                    2:       r.amount = '0;
                    default: r.amount = '1;
                endcase
            end
            default: r.amount = $signed($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
        endcase

        // time steps cluster around friction/2, where damping turns into a jump
        half = t_u64'(cfg_friction) >> 1;
        case ($urandom_range(0, 7))
            0, 1: r.time_step = UVAL_W'($urandom_range(0, 4 * Q_ONE));
            2:    r.time_step = UVAL_W'($urandom);
            3:    r.time_step = UVAL_W'(half - 1);
            4:    r.time_step = UVAL_W'(half);
            5:    r.time_step = UVAL_W'(half + 1);
            default: begin
                if (cfg_friction == '0) r.time_step = UVAL_W'($urandom);
                else r.time_step = UVAL_W'(t_u64'($urandom) % t_u64'(cfg_friction));
            end
        endcase
        return r;
    endfunction

    task automatic add_req(input logic [2:0] cmd, input logic signed [VAL_W-1:0] amt,
                           input logic [UVAL_W-1:0] dt);
        t_gauge_req r;
        r.command = cmd;
        r.amount = amt;
        r.time_step = dt;
        pending_reqs.push_back(r);
    endtask

    // Register write over the config channel; called only with the core idle.
    task automatic write_reg(input t_reg_idx idx, input logic [VAL_W-1:0] value);
        logic [VAL_W-1:0] data;
        data = value;
        // unused top bit of the 31-bit registers gets toggled too
        if (idx != REG_OFFSET) data[VAL_W-1] = 1'($urandom_range(0, 1));
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SCALE:    cfg_scale = data[UVAL_W-1:0];
            REG_OFFSET:   cfg_offset = data;
            REG_FRICTION: cfg_friction = data[UVAL_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_regs(input logic [VAL_W-1:0] scale_val, input logic [VAL_W-1:0] offset_val,
                            input logic [VAL_W-1:0] friction_val);
        write_reg(REG_SCALE, scale_val);
        write_reg(REG_OFFSET, offset_val);
        write_reg(REG_FRICTION, friction_val);
        settings_used++;
        @(negedge i_clk);
    endtask

    // Sender pause: nothing queued, nothing offered, nothing outstanding.
    task automatic wait_drain();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_pos.size() != 0)
            @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Driver: bursts of random length with random gaps. The gap spread
    // is wide so idle cycles land on every point of the serial multiply
    // and divide; gap 0 runs give stretches with no idling at all.
    // ---------------------------------------------------------------
    int         burst_left = 1;
    int         gap_left = 0;
    int unsigned gap_pick;
    t_gauge_req next_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_command   <= '0;
            i_amount    <= '0;
            i_time_step <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_pos.push_back(advance_gauge(i_command, i_amount, i_time_step));
                cmd_seen[i_command]++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    next_req = pending_reqs.pop_front();
                    i_command   <= next_req.command;
                    i_amount    <= next_req.amount;
                    i_time_step <= next_req.time_step;
                    i_in_valid  <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 32);
                        gap_pick = $urandom_range(0, 99);
                        if (gap_pick < 40)      gap_left = 0;
                        else if (gap_pick < 80) gap_left = $urandom_range(1, 4);
                        else if (gap_pick < 95) gap_left = $urandom_range(5, 40);
                        else                    gap_left = $urandom_range(41, 120);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: stall pattern in one of four modes, redrawn at random,
    // plus two long hold-offs while the sender keeps offering, which
    // backs the core up until it refuses new requests.
    // ---------------------------------------------------------------
    t_rx_mode    rx_mode = RX_OPEN;
    logic [15:0] rx_mask = '1;
    int          rx_mode_left = 0;
    int          rx_hold_left = 0;
    int          rx_results = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                rx_results++;
                if (rx_results == 300 || rx_results == 1200) rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    rx_mask = 16'($urandom);
                    rx_mode_left = $urandom_range(16, 160);
                end else begin
                    rx_mode_left--;
                end
                rx_mask = {rx_mask[14:0], rx_mask[15]};
                case (rx_mode)
                    RX_OPEN:    i_out_ready <= 1'b1;
                    RX_PATTERN: i_out_ready <= rx_mask[0];
                    RX_SPARSE:  i_out_ready <= ($urandom_range(0, 3) == 0);
                    default:    i_out_ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: every accepted result against the oldest prediction.
    // ---------------------------------------------------------------
    t_gauge_pos want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pos.size() == 0) begin
                $error("unexpected result: needle_value %h target_value %h",
                       o_needle_value, o_target_value);
                mismatches++;
            end else begin
                want = expected_pos.pop_front();
                results_checked++;
                if (o_needle_value !== want.needle) begin
                    $error("needle_value: expected %0d (%h), got %0d (%h)",
                           want.needle, want.needle, o_needle_value, o_needle_value);
                    mismatches++;
                end
                if (o_target_value !== want.target) begin
                    $error("target_value: expected %0d (%h), got %0d (%h)",
                           want.target, want.target, o_target_value, o_target_value);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence: directed checks under three settings, then random
    // phases, each under its own register setting. Between phases the
    // sender waits for every result before touching the registers.
    // ---------------------------------------------------------------
    initial begin
        int p;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting: scale 1.0, offset 0, friction 0 (ticks always jump)
        add_req(CMD_SET, AMT_MAX, '0);
        add_req(CMD_SET, AMT_MIN, DT_MAX);
        add_req(CMD_PUT, '0, '0);
        add_req(CMD_PUT, '1, '0);                   // -1 lsb floors to -1
        add_req(CMD_INC, 32'sh0001_0000, '0);
        add_req(CMD_INC, AMT_MAX, '0);              // clamps at scale + offset
        add_req(CMD_DEC, 32'sh0002_0000, '0);       // clamps at zero
        add_req(CMD_DEC, AMT_MIN, '0);              // overflow saturates high
        add_req(CMD_PUT, '0, '0);
        add_req(CMD_WRAP, 32'sh0100_0000, '0);      // 256.0, under the 360.0 span
        add_req(CMD_WRAP, 32'sh00C8_0000, '0);      // passes 360.0, wraps both
        add_req(CMD_TICK, 32'sh1234_5678, '0);
        add_req(CMD_SPARE6, AMT_MIN, DT_MAX);
        add_req(CMD_SPARE7, AMT_MAX, DT_MAX);
        wait_drain();

        // friction 4.0: damped steps and the half-friction boundary
        set_regs(VAL_W'(SCALE_RESET), '0, 32'h0004_0000);
        add_req(CMD_SET, 32'sh0064_0000, '0);
        add_req(CMD_TICK, '0, 31'h0001_0000);
        add_req(CMD_TICK, '0, 31'h0001_FFFF);
        add_req(CMD_TICK, '0, 31'h0002_0000);
        add_req(CMD_PUT, AMT_MIN, '0);
        add_req(CMD_SET, AMT_MAX, '0);
        add_req(CMD_TICK, '0, 31'd1);               // full-range difference
        add_req(CMD_TICK, '0, DT_MAX);
        wait_drain();

        // zero scale: scaled amount is zero and the wrap span saturates
        set_regs('0, 32'h7FFF_FFFF, '0);
        add_req(CMD_WRAP, AMT_MAX, '0);
        add_req(CMD_INC, AMT_MIN, '0);
        add_req(CMD_SET, AMT_MIN, '0);
        wait_drain();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: set_regs(VAL_W'(SCALE_RESET), '0, 32'h0004_0000);
                1: set_regs(32'd1, 32'h8000_0000, 32'h7FFF_FFFF);
                2: set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
                3: set_regs(WRAP_SAT_SCALE, -32'sh0010_0000, 32'h0000_8000);
                4: set_regs(WRAP_SAT_SCALE + 1, 32'h0005_0000, 32'h0010_0000);
                5: set_regs('0, $urandom, $urandom);
                6: set_regs(32'h0002_0000, '0, '0);
                default: set_regs(($urandom_range(0, 3) == 0) ? $urandom
                                                               : $urandom_range(1, 4 * Q_ONE),
                                  $signed($urandom_range(0, 128 * Q_ONE)) - 64 * Q_ONE,
                                  $urandom_range(0, 16 * Q_ONE));
            endcase
            repeat (REQS_PER_PHASE) pending_reqs.push_back(rand_req());
            wait_drain();
        end

        // let any stray result show up before the verdict
        repeat (100) @(posedge i_clk);
        $display("run covered %0d results: set %0d put %0d inc %0d dec %0d",
                 results_checked, cmd_seen[CMD_SET], cmd_seen[CMD_PUT], cmd_seen[CMD_INC],
                 cmd_seen[CMD_DEC]);
        $display("  wrap %0d tick %0d spare %0d, over %0d register settings (%0d writes)",
                 cmd_seen[CMD_WRAP], cmd_seen[CMD_TICK],
                 cmd_seen[CMD_SPARE6] + cmd_seen[CMD_SPARE7], settings_used, cfg_writes);
        if (mismatches == 0 && expected_pos.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #(10_000_000);
        $display("tb: errors");
        $finish;
    end

endmodule
